@@ hw/rtl/cagi_pkg.sv @@
// Shared types and constants for the conic arc gradient index block.
// No dependencies; compiled before all other files.
package cagi_pkg;

	localparam int RAMP_STEPS   = 256;
	localparam int MAX_SIDE     = 512;
	localparam int FULL_TURN    = 5760;
	localparam int CORDIC_STEPS = 16;
	localparam int QUARTER_FINE = 368640;

	localparam int CW    = 30;  // CORDIC x/y width
	localparam int ZW    = 22;  // CORDIC angle accumulator width, 1/4096 degree
	localparam int NUM_W = 22;  // divider numerator width
	localparam int DEN_W = 14;  // divider denominator width
	localparam int Q_W   = 8;   // quotient width

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_SIDE   = 3'd0;
	localparam reg_idx_t REG_THICK  = 3'd1;
	localparam reg_idx_t REG_START  = 3'd2;
	localparam reg_idx_t REG_SECTOR = 3'd3;
	localparam reg_idx_t REG_INVERT = 3'd4;

	// sideband carried through the CORDIC pipe
	typedef struct packed {
		logic ring;
		logic zero;
	} cagi_cflags_t;

	// sideband carried through the divider pipe
	typedef struct packed {
		logic ring;
		logic f_one;
		logic f_zero;
	} cagi_dflags_t;

	function automatic logic signed [ZW-1:0] atan_fine(input int unsigned i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = ZW'(184320);
			1: r = ZW'(108810);
			2: r = ZW'(57492);
			3: r = ZW'(29184);
			4: r = ZW'(14649);
			5: r = ZW'(7331);
			6: r = ZW'(3667);
			7: r = ZW'(1833);
			8: r = ZW'(917);
			9: r = ZW'(458);
			10: r = ZW'(229);
			11: r = ZW'(115);
			12: r = ZW'(57);
			13: r = ZW'(29);
			14: r = ZW'(14);
			15: r = ZW'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/cagi_cordic.sv @@
// Pipelined CORDIC vectoring unit: one quadrant fold stage, then one iteration per stage.
// Depends on cagi_pkg.
module cagi_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic signed [9:0]            in_dx,
	input  logic signed [9:0]            in_dy,
	input  cagi_pkg::cagi_cflags_t       in_sb,
	output logic                         out_vld,
	output logic signed [cagi_pkg::ZW-1:0] out_z,
	output cagi_pkg::cagi_cflags_t       out_sb
);
	import cagi_pkg::*;

	logic signed [CW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [0:CORDIC_STEPS];
	cagi_cflags_t         sb_s [0:CORDIC_STEPS];
	logic [CORDIC_STEPS:0] vld_s;

	logic signed [CW-1:0] xin, yin;
	logic signed [CW-1:0] xr, yr;
	logic signed [ZW-1:0] zr;

	assign xin = {{(CW-26){in_dx[9]}}, in_dx, 16'b0};
	assign yin = {{(CW-26){in_dy[9]}}, in_dy, 16'b0};

	// fold the left half plane into the right one
	always_comb begin
		xr = xin;
		yr = yin;
		zr = '0;
		if (xin[CW-1]) begin
			if (!yin[CW-1]) begin
				xr = yin;
				yr = -xin;
				zr = ZW'(QUARTER_FINE);
			end else begin
				xr = -yin;
				yr = xin;
				zr = -ZW'(QUARTER_FINE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[CORDIC_STEPS-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]  <= xr;
		y_s[0]  <= yr;
		z_s[0]  <= zr;
		sb_s[0] <= in_sb;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
		always_ff @(posedge clk) begin
			if (!y_s[k][CW-1]) begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + atan_fine(k);
			end else begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - atan_fine(k);
			end
			sb_s[k+1] <= sb_s[k];
		end
	end

	assign out_vld = vld_s[CORDIC_STEPS];
	assign out_z   = z_s[CORDIC_STEPS];
	assign out_sb  = sb_s[CORDIC_STEPS];

endmodule

@@ hw/rtl/cagi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, quotient known below 2^Q_W.
// Depends on cagi_pkg.
module cagi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [cagi_pkg::NUM_W-1:0]    num,
	input  logic [cagi_pkg::DEN_W-1:0]    den,
	input  cagi_pkg::cagi_dflags_t        in_fl,
	output logic                          out_vld,
	output logic [cagi_pkg::Q_W-1:0]      quo,
	output cagi_pkg::cagi_dflags_t        out_fl
);
	import cagi_pkg::*;

	logic [NUM_W-1:0]  rem_s [1:Q_W];
	logic [Q_W-1:0]    q_s   [1:Q_W];
	cagi_dflags_t      fl_s  [1:Q_W];
	logic [Q_W:1]      vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[Q_W-1:1], in_vld};
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_bit
		logic [NUM_W-1:0] rem_in;
		logic [Q_W-1:0]   q_in;
		logic [Q_W-1:0]   q_nx;
		cagi_dflags_t     fl_in;
		logic [NUM_W-1:0] dsh;
		logic             hit;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign q_in   = '0;
			assign fl_in  = in_fl;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign q_in   = q_s[k];
			assign fl_in  = fl_s[k];
		end

		assign dsh = NUM_W'(den) << (Q_W-1-k);
		assign hit = rem_in >= dsh;

		always_comb begin
			q_nx = q_in;
			q_nx[Q_W-1-k] = hit;
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= hit ? rem_in - dsh : rem_in;
			q_s[k+1]   <= q_nx;
			fl_s[k+1]  <= fl_in;
		end
	end

	assign out_vld = vld_s[Q_W];
	assign quo     = q_s[Q_W];
	assign out_fl  = fl_s[Q_W];

endmodule

@@ hw/rtl/conic_arc_gradient_index.sv @@
// Conic arc gradient index: ring mask and conic ramp step for one pixel per clock.
// Registers from the accepting edge to the edge that takes the result:
// input, square, 17 CORDIC stages, wrap, numerator, 8 divider stages, output.
// Throughput: one pixel per cycle; busy stays low, the pipe never stalls.
// Reset clears the valid bits and loads the register defaults.
// Depends on cagi_pkg, cagi_cordic and cagi_div.
module conic_arc_gradient_index (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [8:0]  pixel_x,
	input  logic [8:0]  pixel_y,
	input  logic        cfg_we,
	input  cagi_pkg::reg_idx_t cfg_addr,
	input  logic [12:0] cfg_wdata,
	output logic        done,
	output logic        in_ring,
	output logic [7:0]  ramp_index
);
	import cagi_pkg::*;

	localparam int LAT = 30;

	logic [9:0]  side_q, thick_q;
	logic [12:0] start_q, span_q;
	logic        inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= 10'd128;
			thick_q <= 10'd16;
			start_q <= '0;
			span_q  <= 13'(FULL_TURN);
			inv_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SIDE:   side_q  <= cfg_wdata[9:0];
				REG_THICK:  thick_q <= cfg_wdata[9:0];
				REG_START:  start_q <= cfg_wdata;
				REG_SECTOR: span_q  <= cfg_wdata;
				REG_INVERT: inv_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// derived configuration; the user keeps it static while items are in flight, the block does not enforce it
	logic [9:0]         side_c;
	logic [12:0]        sector_c, start_c;
	logic [8:0]         ctr;
	logic [10:0]        outer;
	logic signed [12:0] inner_s;
	logic [8:0]         inner;
	logic [21:0]        outer_sq, inner_sq;
	logic [DEN_W-1:0]   den;

	assign side_c   = (side_q > 10'(MAX_SIDE)) ? 10'(MAX_SIDE) : side_q;
	assign sector_c = (span_q > 13'(FULL_TURN)) ? 13'(FULL_TURN) : span_q;
	assign start_c  = (start_q >= 13'(FULL_TURN)) ? start_q - 13'(FULL_TURN) : start_q;
	assign ctr      = side_c[9:1];
	assign outer    = {1'b0, side_c} + 11'd4;
	assign inner_s  = $signed({3'b0, side_c}) - $signed({2'b0, thick_q, 1'b0}) - 13'sd4;
	assign inner    = inner_s[12] ? 9'd0 : inner_s[8:0];
	assign outer_sq = 22'(outer) * 22'(outer);
	assign inner_sq = 22'(inner) * 22'(inner);
	assign den      = {sector_c, 1'b0};

	assign busy = 1'b0;

	// stage 1: capture the pixel
	logic       vld_s1;
	logic [8:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= pixel_x;
		py_s1 <= pixel_y;
	end

	// stage 2: offsets from center and their squares
	logic signed [9:0]  dx_w, dy_w;
	logic signed [19:0] sqx_w, sqy_w;
	logic               ok_w;

	assign dx_w  = $signed({1'b0, px_s1} - {1'b0, ctr});
	assign dy_w  = $signed({1'b0, py_s1} - {1'b0, ctr});
	assign sqx_w = dx_w * dx_w;
	assign sqy_w = dy_w * dy_w;
	assign ok_w  = (side_c != '0) && (sector_c != '0) &&
	               ({1'b0, px_s1} < side_c) && ({1'b0, py_s1} < side_c);

	logic               vld_s2, ok_s2;
	logic signed [9:0]  dx_s2, dy_s2;
	logic signed [19:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx_w;
		dy_s2  <= dy_w;
		sqx_s2 <= sqx_w;
		sqy_s2 <= sqy_w;
		ok_s2  <= ok_w;
	end

	// ring test in quarter-pixel-squared units, then into the CORDIC
	logic [19:0]  dsum;
	logic [21:0]  d4;
	cagi_cflags_t csb_in, csb_out;
	logic         c_vld;
	logic signed [ZW-1:0] c_z;

	assign dsum = 20'(sqx_s2[18:0]) + 20'(sqy_s2[18:0]);
	assign d4   = {dsum, 2'b00};
	assign csb_in.ring = ok_s2 && (d4 <= outer_sq) && (d4 >= inner_sq);
	assign csb_in.zero = (dx_s2 == '0) && (dy_s2 == '0);

	cagi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_dx   (dx_s2),
		.in_dy   (dy_s2),
		.in_sb   (csb_in),
		.out_vld (c_vld),
		.out_z   (c_z),
		.out_sb  (csb_out)
	);

	// stage 3: angle in 1/16 degree, travel from start wrapped into one turn
	logic signed [ZW-1:0] zr;
	logic [13:0]          ang;
	logic [15:0]          t1;
	logic [12:0]          t_w;

	assign zr  = c_z + ZW'(128);
	assign ang = csb_out.zero ? 14'd0 : zr[ZW-1:8];
	assign t1  = {{2{ang[13]}}, ang} - {3'b0, start_c} + 16'(2 * FULL_TURN);

	always_comb begin
		if (t1 >= 16'(2 * FULL_TURN)) begin
			t_w = 13'(t1 - 16'(2 * FULL_TURN));
		end else if (t1 >= 16'(FULL_TURN)) begin
			t_w = 13'(t1 - 16'(FULL_TURN));
		end else begin
			t_w = 13'(t1);
		end
	end

	logic        vld_s3, ring_s3;
	logic [12:0] t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		t_s3    <= t_w;
		ring_s3 <= csb_out.ring;
	end

	// stage 4: snap past the sector end, invert, build the numerator
	logic         past, near;
	logic [13:0]  gap2;
	logic [12:0]  gap_rest, tt;
	cagi_dflags_t dfl_w;
	logic [NUM_W-1:0] num_w;

	assign past     = t_s3 > sector_c;
	assign gap2     = {t_s3 - sector_c, 1'b0};
	assign gap_rest = 13'(FULL_TURN) - sector_c;
	assign near     = gap2 < {1'b0, gap_rest};
	assign dfl_w.ring   = ring_s3;
	assign dfl_w.f_one  = past && (inv_q ? !near : near);
	assign dfl_w.f_zero = past && (inv_q ? near : !near);
	assign tt    = (inv_q && !past) ? sector_c - t_s3 : t_s3;
	assign num_w = NUM_W'(tt) * NUM_W'(2 * (RAMP_STEPS - 1)) + NUM_W'(sector_c);

	logic             vld_s4;
	logic [NUM_W-1:0] num_s4;
	cagi_dflags_t     dfl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s4 <= num_w;
		dfl_s4 <= dfl_w;
	end

	logic         d_vld;
	logic [Q_W-1:0] d_q;
	cagi_dflags_t d_fl;

	cagi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.num     (num_s4),
		.den     (den),
		.in_fl   (dfl_s4),
		.out_vld (d_vld),
		.quo     (d_q),
		.out_fl  (d_fl)
	);

	// output register
	logic [7:0] ramp_w;
	logic       done_q, ring_q;
	logic [7:0] ramp_q;

	always_comb begin
		if (!d_fl.ring || d_fl.f_zero) begin
			ramp_w = '0;
		end else if (d_fl.f_one) begin
			ramp_w = 8'(RAMP_STEPS - 1);
		end else begin
			ramp_w = d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			ring_q <= 1'b0;
		end else begin
			done_q <= d_vld;
			ring_q <= d_vld & d_fl.ring;
		end
	end

	always_ff @(posedge clk) begin
		ramp_q <= ramp_w;
	end

	assign done       = done_q;
	assign in_ring    = ring_q;
	assign ramp_index = ramp_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted pixel did not produce a result on time");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		d_vld |=> done)
		else $error("divider result lost at the output register");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!d_vld |=> !done)
		else $error("result strobe without a divider beat");

	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_ring |-> ramp_index == '0)
		else $error("pixel outside the ring carries a nonzero ramp step");

endmodule
